>>> design/tefc_pkg.sv
package tefc_pkg;

   // storage format codes held in the element_format register
   typedef enum logic [1:0] {
      FMT_FP32 = 2'd0,
      FMT_FP16 = 2'd1,
      FMT_BF16 = 2'd2,
      FMT_BOOL = 2'd3
   } fmt_type;

   // register index (byte address / 4)
   typedef enum logic [1:0] {
      REG_FORMAT   = 2'd0,
      REG_SENTINEL = 2'd1,
      REG_PADCODE  = 2'd2
   } reg_idx_type;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   localparam int unsigned CSR_ADDR_W = 4;

   localparam logic [31:0] FP32_EXP_MASK = 32'h7F80_0000;
   localparam logic [31:0] FP32_ONE      = 32'h3F80_0000;
   localparam logic [31:0] FP32_MAG_MASK = 32'h7FFF_FFFF;
   localparam logic [14:0] HALF_INF      = 15'h7C00;
   localparam logic [15:0] BF16_QUIET    = 16'h0040;
   localparam logic [31:0] BF16_RND_BIAS = 32'h0000_7FFF;
   localparam logic [7:0]  HALF_EXP_BIAS = 8'd112;

   localparam logic [31:0] SENTINEL_RESET = 32'hFF80_0000;
   localparam logic [7:0]  PADCODE_RESET  = 8'hFF;

   // stage 2 payload: result before the final rounding increment
   typedef struct packed {
      logic [31:0] base;
      logic        inc;
      logic        bad;
   } stage_type;

endpackage

>>> design/tefc_half_enc.sv
module tefc_half_enc (
   input  logic [31:0] value,
   output logic [15:0] base,
   output logic        inc
);
   import tefc_pkg::*;

   logic        sign;
   logic [7:0]  expo;
   logic [22:0] man;
   logic [23:0] full;
   logic [4:0]  sh;
   logic [23:0] kept;
   logic [23:0] low_mask;
   logic        guard;
   logic        sticky;
   logic [7:0]  hexp;

   assign sign     = value[31];
   assign expo     = value[30:23];
   assign man      = value[22:0];
   assign full     = {1'b1, man};
   // subnormal result: right shift of 14..24 over the significand with hidden bit
   assign sh       = 5'(8'd126 - expo);
   assign kept     = full >> sh;
   assign low_mask = (24'd1 << (sh - 5'd1)) - 24'd1;
   assign guard    = full[sh - 5'd1];
   assign sticky   = |(full & low_mask);
   assign hexp     = expo - HALF_EXP_BIAS;

   always_comb begin
      base = {sign, 15'd0};
      inc  = 1'b0;
      if (expo == 8'hFF) begin
         if (man == 23'd0) begin
            base = {sign, HALF_INF};
         end else if (man[22:13] == 10'd0) begin
            base = {sign, HALF_INF | 15'd1};
         end else begin
            base = {sign, HALF_INF | {5'd0, man[22:13]}};
         end
      end else if (expo >= 8'd143) begin
         base = {sign, HALF_INF};
      end else if (expo >= 8'd113) begin
         // carry from the increment runs into the exponent, up to infinity
         base = {sign, hexp[4:0], man[22:13]};
         inc  = man[12] & ((|man[11:0]) | man[13]);
      end else if (expo >= 8'd102) begin
         base = {sign, 5'd0, kept[9:0]};
         inc  = guard & (sticky | kept[0]);
      end
   end

endmodule

>>> design/tefc_half_dec.sv
module tefc_half_dec (
   input  logic [15:0] half,
   output logic [31:0] single
);
   import tefc_pkg::*;

   logic        sign;
   logic [4:0]  expo;
   logic [9:0]  man;
   logic [3:0]  lead;
   logic [3:0]  shift;
   logic [10:0] norm;

   assign sign  = half[15];
   assign expo  = half[14:10];
   assign man   = half[9:0];
   assign shift = 4'd10 - lead;
   assign norm  = {1'b0, man} << shift;

   always_comb begin
      lead = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (man[i]) begin
            lead = 4'(i);
         end
      end
   end

   always_comb begin
      if (expo == 5'd0) begin
         if (man == 10'd0) begin
            single = {sign, 31'd0};
         end else begin
            single = {sign, 8'd103 + {4'd0, lead}, norm[9:0], 13'd0};
         end
      end else if (expo == 5'h1F) begin
         single = {sign, 8'hFF, man, 13'd0};
      end else begin
         single = {sign, {3'd0, expo} + HALF_EXP_BIAS, man, 13'd0};
      end
   end

endmodule

>>> design/tensor_element_format_converter.sv
// Three register stages lie between start and rsp_valid: input, convert and output.
// Throughput: one item per cycle; busy is never raised.
// The result strobe is a single cycle and the receiver cannot stall it.
// Synchronous active-high reset clears the valid bits and sets the registers
// to fp32, sentinel -infinity and padding code 0xFF.
module tensor_element_format_converter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_op,
   input  logic [31:0]                      req_value_bits,
   output logic                             rsp_valid,
   output logic [31:0]                      rsp_result_bits,
   output logic                             rsp_not_canonical,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tefc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import tefc_pkg::*;

   fmt_type          format_ff;
   logic [31:0]      sentinel_ff;
   logic [7:0]       padcode_ff;
   reg_idx_type      csr_idx;
   logic             csr_wr;

   logic             s1_valid_ff;
   logic             s1_op_ff;
   logic [31:0]      s1_value_ff;

   logic             s2_valid_ff;
   stage_type        s2_ff;
   stage_type        s2_in;

   logic             out_valid_ff;
   logic [31:0]      out_result_ff;
   logic             out_bad_ff;

   logic [15:0]      henc_base;
   logic             henc_inc;
   logic [31:0]      hdec_single;
   logic             v_nan;
   logic             s_nan;
   logic             pad_match;
   logic [31:0]      bf16_sum;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   // ---------------- register file
   assign csr_idx = reg_idx_type'(paddr[3:2]);
   assign csr_wr  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff   <= FMT_FP32;
         sentinel_ff <= SENTINEL_RESET;
         padcode_ff  <= PADCODE_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_FORMAT:   format_ff   <= fmt_type'(pwdata[1:0]);
            REG_SENTINEL: sentinel_ff <= pwdata;
            REG_PADCODE:  padcode_ff  <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_FORMAT:   prdata = {30'd0, format_ff};
         REG_SENTINEL: prdata = sentinel_ff;
         REG_PADCODE:  prdata = {24'd0, padcode_ff};
         default:      prdata = 32'd0;
      endcase
   end

   // ---------------- stage 1: capture item
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff    <= req_op;
      s1_value_ff <= req_value_bits;
   end

   // ---------------- stage 2: convert, rounding increment deferred
   tefc_half_enc u_half_enc (
      .value (s1_value_ff),
      .base  (henc_base),
      .inc   (henc_inc)
   );

   tefc_half_dec u_half_dec (
      .half   (s1_value_ff[15:0]),
      .single (hdec_single)
   );

   assign v_nan = ((s1_value_ff & FP32_EXP_MASK) == FP32_EXP_MASK) && (s1_value_ff[22:0] != 23'd0);
   assign s_nan = ((sentinel_ff & FP32_EXP_MASK) == FP32_EXP_MASK) && (sentinel_ff[22:0] != 23'd0);
   // IEEE equality: NaN never matches, signed zeros match
   assign pad_match = ~v_nan & ~s_nan &
                      ((((s1_value_ff | sentinel_ff) & FP32_MAG_MASK) == 32'd0) ||
                       (s1_value_ff == sentinel_ff));
   assign bf16_sum  = s1_value_ff + BF16_RND_BIAS + {31'd0, s1_value_ff[16]};

   always_comb begin
      s2_in = '{base: 32'd0, inc: 1'b0, bad: 1'b0};
      if (s1_op_ff == OP_ENCODE) begin
         case (format_ff)
            FMT_FP32: s2_in.base = s1_value_ff;
            FMT_FP16: begin
               s2_in.base = {16'd0, henc_base};
               s2_in.inc  = henc_inc;
            end
            FMT_BF16: begin
               if (v_nan) begin
                  s2_in.base = {16'd0, s1_value_ff[31:16] | BF16_QUIET};
               end else begin
                  s2_in.base = {16'd0, bf16_sum[31:16]};
               end
            end
            default: begin
               if (pad_match) begin
                  s2_in.base = {24'd0, padcode_ff};
               end else if ((s1_value_ff & FP32_MAG_MASK) == 32'd0) begin
                  s2_in.base = 32'd0;
               end else if (s1_value_ff == FP32_ONE) begin
                  s2_in.base = 32'd1;
               end else begin
                  s2_in.bad = 1'b1;
               end
            end
         endcase
      end else begin
         case (format_ff)
            FMT_FP32: s2_in.base = s1_value_ff;
            FMT_FP16: s2_in.base = hdec_single;
            FMT_BF16: s2_in.base = {s1_value_ff[15:0], 16'd0};
            default: begin
               if (s1_value_ff[7:0] == 8'd0) begin
                  s2_in.base = 32'd0;
               end else if (s1_value_ff[7:0] == 8'd1) begin
                  s2_in.base = FP32_ONE;
               end else begin
                  s2_in.bad = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff <= s2_in;
   end

   // ---------------- stage 3: apply increment, output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   // magnitude never carries into the fp16 sign bit
   always_ff @(posedge clock) begin
      out_result_ff <= {s2_ff.base[31:15], s2_ff.base[14:0] + {14'd0, s2_ff.inc}};
      out_bad_ff    <= s2_ff.bad;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_result_bits   = out_result_ff;
   assign rsp_not_canonical = out_bad_ff;

endmodule
